>>> rtl/rhwm_pkg.sv
`default_nettype none

package rhwm_pkg;

  localparam int CHAN_W           = 8;
  localparam int POS_W            = 12;
  localparam int DIFF_W           = 19;
  localparam int NUM_CHANNELS     = 3;
  localparam int BINS_PER_CHANNEL = 4;
  localparam int NUM_BINS         = NUM_CHANNELS * BINS_PER_CHANNEL;
  // equal bins of 64 codes each, so the bin is the top bits of the channel value
  localparam int BIN_SEL_W        = $clog2(BINS_PER_CHANNEL);

  localparam logic [DIFF_W-1:0] DIFF_MAX = '1;

  localparam logic CMD_REFERENCE = 1'b0;
  localparam logic CMD_CANDIDATE = 1'b1;

  // first field in the highest bits
  typedef struct packed {
    logic [POS_W-1:0]  window_y;
    logic [POS_W-1:0]  window_x;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
  } pixel_t;

  typedef struct packed {
    logic [POS_W-1:0]  result_y;
    logic [POS_W-1:0]  result_x;
    logic [POS_W-1:0]  best_y;
    logic [POS_W-1:0]  best_x;
    logic [DIFF_W-1:0] best_difference;
    logic              exact_match;
    logic              new_best;
    logic [DIFF_W-1:0] difference;
  } result_t;

  localparam int IN_TDATA_W  = $bits(pixel_t);
  localparam int OUT_TDATA_W = $bits(result_t);

endpackage

`default_nettype wire

>>> rtl/rgb_histogram_window_matcher_top.sv
// a pixel is taken into the input register; a closing candidate pixel then loads the result
// register once that register is free, else it waits until the held result drains
// throughput: one pixel per cycle, set by the combinational bin update and twelve-term sad;
// only a closing candidate pixel waits on a held result, and the input stalls behind it
// reset (rst_n low, synchronous): histograms cleared, best difference all ones, best
// position zero, both pipeline valid flags cleared
`default_nettype none

module rgb_histogram_window_matcher_top #(
  parameter int unsigned MAX_WINDOW_PIXELS = 65536
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [rhwm_pkg::IN_TDATA_W-1:0]  in_tdata,  // red, green, blue, window_x, window_y
  input  wire logic                             in_tuser,  // command
  input  wire logic                             in_tlast,  // window_end
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // difference, new_best, exact_match, best_difference, best_x, best_y, result_x, result_y
  output logic [rhwm_pkg::OUT_TDATA_W-1:0]      out_tdata
);

  import rhwm_pkg::*;

  localparam int BIN_W = $clog2(MAX_WINDOW_PIXELS + 1);
  localparam int SUM_W = BIN_W + 4;
  localparam int CMP_W = (SUM_W > DIFF_W) ? SUM_W : DIFF_W;
  localparam logic [BIN_W-1:0] BIN_MAX = BIN_W'(MAX_WINDOW_PIXELS);

  // input register
  logic       s1_valid_r;
  pixel_t     s1_pix_r;
  logic       s1_cmd_r;
  logic       s1_last_r;

  // histogram and best-match state
  logic [BIN_W-1:0]  work_r [NUM_BINS];
  logic [BIN_W-1:0]  ref_r  [NUM_BINS];
  logic [DIFF_W-1:0] lowest_r;
  logic [POS_W-1:0]  lowest_x_r;
  logic [POS_W-1:0]  lowest_y_r;

  // result register
  logic    out_valid_r;
  result_t out_r;
  result_t out_nxt;

  logic [BIN_SEL_W-1:0] sel [NUM_CHANNELS];
  logic [BIN_W-1:0]     counted [NUM_BINS];
  logic [BIN_W-1:0]     absd [NUM_BINS];
  logic [SUM_W-1:0]     lvl1 [NUM_BINS/2];
  logic [SUM_W-1:0]     lvl2 [NUM_BINS/4];
  logic [SUM_W-1:0]     total;
  logic [DIFF_W-1:0]    diff;
  logic                 better;
  logic                 closes_candidate;
  logic                 out_free;
  logic                 s2_go;
  logic                 emit_go;

  assign sel[0] = s1_pix_r.red[CHAN_W-1 -: BIN_SEL_W];
  assign sel[1] = s1_pix_r.green[CHAN_W-1 -: BIN_SEL_W];
  assign sel[2] = s1_pix_r.blue[CHAN_W-1 -: BIN_SEL_W];

  // count the pixel into its bin of each channel, stopping at the window limit
  always_comb begin
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      for (int b = 0; b < BINS_PER_CHANNEL; b++) begin
        counted[c*BINS_PER_CHANNEL + b] = work_r[c*BINS_PER_CHANNEL + b];
        if (sel[c] == BIN_SEL_W'(b) && work_r[c*BINS_PER_CHANNEL + b] < BIN_MAX) begin
          counted[c*BINS_PER_CHANNEL + b] = work_r[c*BINS_PER_CHANNEL + b] + 1'b1;
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_BINS; i++) begin
      if (counted[i] > ref_r[i]) begin
        absd[i] = counted[i] - ref_r[i];
      end else begin
        absd[i] = ref_r[i] - counted[i];
      end
    end
  end

  // adder tree: twelve terms to six to three to one
  always_comb begin
    for (int i = 0; i < NUM_BINS/2; i++) begin
      lvl1[i] = SUM_W'(absd[2*i]) + SUM_W'(absd[2*i+1]);
    end
    for (int i = 0; i < NUM_BINS/4; i++) begin
      lvl2[i] = lvl1[2*i] + lvl1[2*i+1];
    end
    total = lvl2[0] + lvl2[1] + lvl2[2];
  end

  assign diff   = (CMP_W'(total) > CMP_W'(DIFF_MAX)) ? DIFF_MAX : DIFF_W'(total);
  assign better = diff < lowest_r;

  assign closes_candidate = s1_last_r && (s1_cmd_r == CMD_CANDIDATE);
  assign out_free  = !out_valid_r || out_tready;
  assign s2_go     = s1_valid_r && (!closes_candidate || out_free);
  assign emit_go   = s2_go && closes_candidate;
  assign in_tready = !s1_valid_r || s2_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_pix_r  <= pixel_t'(in_tdata);
      s1_cmd_r  <= in_tuser;
      s1_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        work_r[i] <= '0;
        ref_r[i]  <= '0;
      end
      lowest_r   <= DIFF_MAX;
      lowest_x_r <= '0;
      lowest_y_r <= '0;
    end else if (s2_go) begin
      if (s1_last_r) begin
        for (int i = 0; i < NUM_BINS; i++) begin
          work_r[i] <= '0;
        end
        if (s1_cmd_r == CMD_REFERENCE) begin
          for (int i = 0; i < NUM_BINS; i++) begin
            ref_r[i] <= counted[i];
          end
          lowest_r   <= DIFF_MAX;
          lowest_x_r <= '0;
          lowest_y_r <= '0;
        end else if (better) begin
          lowest_r   <= diff;
          lowest_x_r <= s1_pix_r.window_x;
          lowest_y_r <= s1_pix_r.window_y;
        end
      end else begin
        for (int i = 0; i < NUM_BINS; i++) begin
          work_r[i] <= counted[i];
        end
      end
    end
  end

  always_comb begin
    out_nxt.difference      = diff;
    out_nxt.new_best        = better;
    out_nxt.best_difference = better ? diff : lowest_r;
    out_nxt.exact_match     = (out_nxt.best_difference == '0);
    out_nxt.best_x          = better ? s1_pix_r.window_x : lowest_x_r;
    out_nxt.best_y          = better ? s1_pix_r.window_y : lowest_y_r;
    out_nxt.result_x        = s1_pix_r.window_x;
    out_nxt.result_y        = s1_pix_r.window_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // best can never be worse than the window just scored
  a_best_not_above_diff: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.best_difference <= out_r.difference)
    else $error("best difference above current difference");

  // a new best carries this window's score and position
  a_new_best_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.new_best |->
      out_r.best_difference == out_r.difference &&
      out_r.best_x == out_r.result_x && out_r.best_y == out_r.result_y)
    else $error("new best does not match current window");

  a_exact_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.exact_match == (out_r.best_difference == '0))
    else $error("exact match flag inconsistent");

  // a reference window close forgets the best match
  a_ref_close_resets_best: assert property (@(posedge clk) disable iff (!rst_n)
    s2_go && s1_last_r && s1_cmd_r == CMD_REFERENCE |=>
      lowest_r == DIFF_MAX && lowest_x_r == '0 && lowest_y_r == '0)
    else $error("best match not cleared on reference close");

endmodule

`default_nettype wire

>>> dv/rgb_histogram_window_matcher_top_test.sv
`default_nettype none

module rgb_histogram_window_matcher_top_test;

  import rhwm_pkg::*;

  localparam int unsigned MAX_PIX        = 65536;
  localparam int          RANDOM_PIXELS  = 750;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          NUM_ROWS       = 12;

  typedef pixel_t pixel_q_t[$];

  // one row is a run of identical pixels; only the last may close the window
  typedef struct {
    logic              cmd;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    int                reps;
    logic              last;
    bit                typed;
    logic [DIFF_W-1:0] sad;
    logic              took_best;
    logic              exact;
    logic [DIFF_W-1:0] best_sad;
    logic [POS_W-1:0]  best_col;
    logic [POS_W-1:0]  best_row;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;  // red, green, blue, window_x, window_y
  logic                   in_tuser   = 1'b0;  // command
  logic                   in_tlast   = 1'b0;  // window_end
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;  // difference, new_best, exact_match, best_difference,
                                      // best_x, best_y, result_x, result_y

  // histogram predictor state
  logic [16:0]       open_bins      [NUM_BINS];
  logic [16:0]       reference_hist [NUM_BINS];
  logic [DIFF_W-1:0] best_sad;
  logic [POS_W-1:0]  best_col;
  logic [POS_W-1:0]  best_row;

  result_t   pending_results[$];
  stim_row_t plan [NUM_ROWS];

  int  mismatches    = 0;
  int  pixels_sent   = 0;
  int  ref_windows   = 0;
  int  cand_windows  = 0;
  int  results_seen  = 0;
  int  exact_seen    = 0;
  int  best_seen     = 0;
  int  idle_cycles   = 0;
  int  stall_left    = 0;
  bit  calm          = 1'b0;

  rgb_histogram_window_matcher_top #(
    .MAX_WINDOW_PIXELS(MAX_PIX)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d, wanted %0d", results_seen, name, got,
                                want));
  endtask

  // mostly short gaps, a few long ones, none while things are calm
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int unsigned level_bin(input logic [CHAN_W-1:0] v);
    if (v < 64) return 0;
    if (v < 128) return 1;
    if (v < 192) return 2;
    return 3;
  endfunction

  task automatic bump_bin(input int unsigned idx);
    if (open_bins[idx] < MAX_PIX) open_bins[idx] = open_bins[idx] + 1'b1;
  endtask

  task automatic histogram_step(input logic cmd, input pixel_t px, input logic last,
                                output bit emits, output result_t res);
    int unsigned sad;
    int unsigned a;
    int unsigned b;
    bit          better;
    emits = 1'b0;
    res   = '0;
    bump_bin(0 * BINS_PER_CHANNEL + level_bin(px.red));
    bump_bin(1 * BINS_PER_CHANNEL + level_bin(px.green));
    bump_bin(2 * BINS_PER_CHANNEL + level_bin(px.blue));
    if (!last) return;
    if (cmd == CMD_REFERENCE) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        reference_hist[i] = open_bins[i];
        open_bins[i]      = '0;
      end
      best_sad = DIFF_MAX;
      best_col = '0;
      best_row = '0;
      ref_windows++;
      return;
    end
    sad = 0;
    for (int i = 0; i < NUM_BINS; i++) begin
      a = open_bins[i];
      b = reference_hist[i];
      sad += (a > b) ? a - b : b - a;
      open_bins[i] = '0;
    end
    if (sad > DIFF_MAX) sad = DIFF_MAX;
    better = sad < best_sad;
    if (better) begin
      best_sad = sad[DIFF_W-1:0];
      best_col = px.window_x;
      best_row = px.window_y;
    end
    res.difference      = sad[DIFF_W-1:0];
    res.new_best        = better;
    res.exact_match     = (best_sad == '0);
    res.best_difference = best_sad;
    res.best_x          = best_col;
    res.best_y          = best_row;
    res.result_x        = px.window_x;
    res.result_y        = px.window_y;
    emits               = 1'b1;
    cand_windows++;
  endtask

  // leaves tvalid high so that a following call streams without a bubble
  task automatic send_pixel(input logic cmd, input pixel_t px, input logic last,
                            input bit may_pause, input bit use_typed = 1'b0,
                            input result_t typed_res = '0);
    int      gap;
    bit      emits;
    result_t res;
    gap = may_pause ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = px;
    in_tuser  = cmd;
    in_tlast  = last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pixels_sent++;
    histogram_step(cmd, px, last, emits, res);
    if (emits) begin
      if (use_typed) res = typed_res;
      pending_results = {pending_results, res};
    end
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // all pixels of a window carry its position; mixed windows scramble the
  // command on every pixel but the closing one
  task automatic send_window(input logic end_cmd, input pixel_q_t pix_q, input bit mixed);
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             cmd;
    col = POS_W'($urandom_range(0, 4095));
    row = POS_W'($urandom_range(0, 4095));
    foreach (pix_q[i]) begin
      pix_q[i].window_x = col;
      pix_q[i].window_y = row;
      cmd = (mixed && i != pix_q.size() - 1) ? logic'($urandom_range(0, 1)) : end_cmd;
      send_pixel(cmd, pix_q[i], i == pix_q.size() - 1, 1'b1);
    end
  endtask

  function automatic logic [CHAN_W-1:0] random_level();
    logic [CHAN_W-1:0] bounds [8];
    bounds = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
    if ($urandom_range(0, 3) == 0) return bounds[$urandom_range(0, 7)];
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    px       = '0;
    px.red   = random_level();
    px.green = random_level();
    px.blue  = random_level();
    return px;
  endfunction

  function automatic int window_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 16);
    return $urandom_range(17, 48);
  endfunction

  function automatic pixel_q_t random_window(input int len);
    pixel_q_t q;
    repeat (len) q = {q, random_pixel()};
    return q;
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else begin
      out_tready = 1'b1;
      stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin : result_check
    result_t got_res;
    result_t want_res;
    if (rst_n && out_tvalid && out_tready) begin
      got_res = result_t'(out_tdata);
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing pending", results_seen));
      end else begin
        want_res = pending_results.pop_front();
        compare_field("difference", got_res.difference, want_res.difference);
        compare_field("new_best", got_res.new_best, want_res.new_best);
        compare_field("exact_match", got_res.exact_match, want_res.exact_match);
        compare_field("best_difference", got_res.best_difference, want_res.best_difference);
        compare_field("best_x", got_res.best_x, want_res.best_x);
        compare_field("best_y", got_res.best_y, want_res.best_y);
        compare_field("result_x", got_res.result_x, want_res.result_x);
        compare_field("result_y", got_res.result_y, want_res.result_y);
      end
      if (got_res.exact_match) exact_seen++;
      if (got_res.new_best) best_seen++;
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    pixel_t   px;
    result_t  typed_res;
    pixel_q_t ref_q;
    pixel_q_t cand_q;
    pixel_q_t pool;
    int       idx;
    int       pick;
    int       random_start;

    for (int i = 0; i < NUM_BINS; i++) begin
      open_bins[i]      = '0;
      reference_hist[i] = '0;
    end
    best_sad = DIFF_MAX;
    best_col = '0;
    best_row = '0;

    plan = '{
      // fresh from reset: empty reference, no best yet
      '{CMD_CANDIDATE, 8'd0, 8'd0, 8'd0, 12'd0, 12'd0, 1, 1'b1,
        1'b1, 19'd3, 1'b1, 1'b0, 19'd3, 12'd0, 12'd0},
      // equal sum, earlier best stays
      '{CMD_CANDIDATE, 8'd255, 8'd255, 8'd255, 12'd4095, 12'd4095, 1, 1'b1,
        1'b1, 19'd3, 1'b0, 1'b0, 19'd3, 12'd0, 12'd0},
      // reference across the bin bounds
      '{CMD_REFERENCE, 8'd63, 8'd64, 8'd127, 12'd0, 12'd0, 1, 1'b0,
        1'b0, '0, 1'b0, 1'b0, '0, '0, '0},
      '{CMD_REFERENCE, 8'd128, 8'd191, 8'd192, 12'd0, 12'd0, 1, 1'b1,
        1'b0, '0, 1'b0, 1'b0, '0, '0, '0},
      // mixed commands, closing pixel decides
      '{CMD_REFERENCE, 8'd63, 8'd64, 8'd127, 12'd9, 12'd9, 1, 1'b0,
        1'b0, '0, 1'b0, 1'b0, '0, '0, '0},
      '{CMD_CANDIDATE, 8'd128, 8'd191, 8'd192, 12'd100, 12'd200, 1, 1'b1,
        1'b1, 19'd0, 1'b1, 1'b1, 19'd0, 12'd100, 12'd200},
      // after an exact match the block carries on
      '{CMD_CANDIDATE, 8'd63, 8'd64, 8'd127, 12'd1, 12'd1, 1, 1'b0,
        1'b0, '0, 1'b0, 1'b0, '0, '0, '0},
      '{CMD_CANDIDATE, 8'd128, 8'd191, 8'd192, 12'd5, 12'd6, 1, 1'b1,
        1'b1, 19'd0, 1'b0, 1'b1, 19'd0, 12'd100, 12'd200},
      // a new reference forgets the best match
      '{CMD_CANDIDATE, 8'd255, 8'd0, 8'd128, 12'd0, 12'd0, 1, 1'b0,
        1'b0, '0, 1'b0, 1'b0, '0, '0, '0},
      '{CMD_REFERENCE, 8'd0, 8'd255, 8'd64, 12'd0, 12'd0, 1, 1'b1,
        1'b0, '0, 1'b0, 1'b0, '0, '0, '0},
      '{CMD_CANDIDATE, 8'd0, 8'd0, 8'd0, 12'd1, 12'd2, 1, 1'b1,
        1'b1, 19'd5, 1'b1, 1'b0, 19'd5, 12'd1, 12'd2},
      '{CMD_CANDIDATE, 8'd200, 8'd10, 8'd70, 12'd3, 12'd3, 1, 1'b1,
        1'b0, '0, 1'b0, 1'b0, '0, '0, '0}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < NUM_ROWS; r++) begin
      px                        = '0;
      px.red                    = plan[r].red;
      px.green                  = plan[r].green;
      px.blue                   = plan[r].blue;
      px.window_x               = plan[r].col;
      px.window_y               = plan[r].row;
      typed_res.difference      = plan[r].sad;
      typed_res.new_best        = plan[r].took_best;
      typed_res.exact_match     = plan[r].exact;
      typed_res.best_difference = plan[r].best_sad;
      typed_res.best_x          = plan[r].best_col;
      typed_res.best_y          = plan[r].best_row;
      typed_res.result_x        = plan[r].col;
      typed_res.result_y        = plan[r].row;
      for (int k = 0; k < plan[r].reps; k++)
        send_pixel(plan[r].cmd, px, plan[r].last && k == plan[r].reps - 1,
                   plan[r].reps < 16, plan[r].typed, typed_res);
    end

    // hold the sender until the directed results are all back
    drain_results();

    random_start = pixels_sent;
    while (pixels_sent - random_start < RANDOM_PIXELS) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      if ($urandom_range(0, 19) == 0) drain_results();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        ref_q = random_window(window_length());
        send_window(CMD_REFERENCE, ref_q, $urandom_range(0, 9) == 0);
        repeat ($urandom_range(1, 5)) begin
          case ($urandom_range(0, 2))
            0: begin
              // same pixels in another order
              pool = ref_q;
              cand_q.delete();
              while (pool.size() != 0) begin
                idx = $urandom_range(0, pool.size() - 1);
                cand_q = {cand_q, pool[idx]};
                pool.delete(idx);
              end
            end
            1: begin
              cand_q = ref_q;
              repeat ($urandom_range(1, 2))
                cand_q[$urandom_range(0, cand_q.size() - 1)] = random_pixel();
              if ($urandom_range(0, 1) == 1) cand_q = {cand_q, random_pixel()};
            end
            default: cand_q = random_window(window_length());
          endcase
          send_window(CMD_CANDIDATE, cand_q, $urandom_range(0, 9) == 0);
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 3))
          send_window(CMD_CANDIDATE, random_window(window_length()), 1'b0);
      end else begin
        send_window(logic'($urandom_range(0, 1)), random_window(window_length()), 1'b1);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);

    $display("%0d pixels sent, %0d reference and %0d candidate windows closed, %0d results",
             pixels_sent, ref_windows, cand_windows, results_seen);
    $display("%0d results improved the best match, %0d carried an exact match",
             best_seen, exact_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/rhwm_pkg.sv
rtl/rgb_histogram_window_matcher_top.sv
dv/rgb_histogram_window_matcher_top_test.sv
